>>> rtl/pairwise_gravity_impulse_top_assert.svh
// Assertion macros shared by the pairwise gravity impulse RTL.
`ifndef PAIRWISE_GRAVITY_IMPULSE_TOP_ASSERT_SVH
`define PAIRWISE_GRAVITY_IMPULSE_TOP_ASSERT_SVH

// Same-cycle implication on clock, off while reset is high.
`define PGI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on clock, off while reset is high.
`define PGI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pgi_pkg.sv
// Types, constants and helpers for the pairwise gravity impulse block.
package pgi_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int Q_W           = 32;
   localparam int ROOT_W        = 33;
   localparam int FIFO_DEPTH    = 4;
   localparam int ADDR_W        = 4;

   localparam logic        ENABLE_RESET = 1'b0;
   localparam logic [31:0] GRAV_RESET   = 32'h0001_0000;
   localparam logic [31:0] LIMIT_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] DT_RESET     = 32'h0001_0000;

   typedef enum logic [1:0] {
      REG_ENABLE = 2'd0,
      REG_GRAV   = 2'd1,
      REG_LIMIT  = 2'd2,
      REG_DT     = 2'd3
   } pgi_reg_type;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic [31:0]        mass_a;
      logic [31:0]        mass_b;
      logic               fixed_a;
      logic               fixed_b;
      logic               removed_a;
      logic               removed_b;
   } pgi_req_type;

   typedef struct packed {
      logic signed [31:0] nudge_a_x;
      logic signed [31:0] nudge_a_y;
      logic signed [31:0] nudge_b_x;
      logic signed [31:0] nudge_b_y;
      logic               apply_a;
      logic               apply_b;
      logic               singular;
   } pgi_rsp_type;

   typedef struct packed {
      logic        active;
      logic        singular;
      logic        fixed_a;
      logic        fixed_b;
      logic        neg_x;
      logic        neg_y;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] mass_a;
      logic [31:0] mass_b;
   } pgi_work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pgi_fifo_stat_type;

   typedef struct packed {
      logic [31:0] grav_constant;
      logic [31:0] force_limit;
      logic [63:0] dt_sq;
   } pgi_cfg_type;

   function automatic logic [31:0] sat_nudge(input logic [31:0] q, input logic neg);
      logic [31:0] r;
      if (q == 32'd0) begin
         r = 32'd0;
      end else if (neg) begin
         r = (q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
      end else begin
         r = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
      end
      return r;
   endfunction

endpackage

>>> rtl/pairwise_gravity_impulse_top.sv
// Pairwise gravity impulse: CSR block, front classifier, work queue, back pipeline.
// Throughput: one pair per cycle while the response is not stalled; the root and divider pipelines set the depth.
// A stalled response holds the back pipeline; the 4-entry queue keeps the front moving.
// Reset is synchronous and active high: clears valids, the queue and the CSRs to defaults.
module pairwise_gravity_impulse_top
   import pgi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgi_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgi_rsp_type       rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic              enable_ff;
   logic [31:0]       grav_ff, limit_ff, dt_ff;
   logic [63:0]       dt_sq_ff;
   logic              csr_wr;
   pgi_reg_type       csr_sel;
   pgi_cfg_type       cfg;
   pgi_fifo_stat_type fifo_stat;
   pgi_work_type      push_data, head;
   logic              push, pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = pgi_reg_type'(csr_paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RESET;
         grav_ff   <= GRAV_RESET;
         limit_ff  <= LIMIT_RESET;
         dt_ff     <= DT_RESET;
      end else if (csr_wr) begin
         case (csr_sel)
            REG_ENABLE: begin
               enable_ff <= csr_pwdata[0];
            end
            REG_GRAV: begin
               grav_ff <= csr_pwdata;
            end
            REG_LIMIT: begin
               limit_ff <= csr_pwdata;
            end
            REG_DT: begin
               dt_ff <= csr_pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      dt_sq_ff <= 64'(dt_ff) * 64'(dt_ff);
   end

   always_comb begin
      case (csr_sel)
         REG_ENABLE: csr_prdata = {31'd0, enable_ff};
         REG_GRAV:   csr_prdata = grav_ff;
         REG_LIMIT:  csr_prdata = limit_ff;
         REG_DT:     csr_prdata = dt_ff;
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.grav_constant = grav_ff;
   assign cfg.force_limit   = limit_ff;
   assign cfg.dt_sq         = dt_sq_ff;

   pgi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .gravity_enable(enable_ff),
      .fifo_stat     (fifo_stat),
      .push          (push),
      .push_data     (push_data)
   );

   pgi_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .stat     (fifo_stat)
   );

   pgi_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fifo_stat(fifo_stat),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/pgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module pgi_div
   import pgi_pkg::*;
#(
   parameter int NUM_W = 96,
   parameter int DEN_W = 65
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [REM_W-1:0] rem_ff   [0:Q_W];
   logic [DEN_W-1:0] den_ff   [0:Q_W];
   logic [Q_W-1:0]   q_ff     [0:Q_W];
   logic             sat_ff   [0:Q_W];
   logic [REM_W-1:0] rem_in   [1:Q_W];
   logic [Q_W-1:0]   q_in     [1:Q_W];
   logic [REM_W-1:0] trial    [1:Q_W];
   logic [REM_W-1:0] num_ext;
   logic [REM_W-1:0] den_top;

   always_comb begin
      num_ext = REM_W'(num);
      den_top = REM_W'(den) << Q_W;
   end

   always_comb begin
      for (int j = 1; j <= Q_W; j++) begin
         trial[j] = REM_W'(den_ff[j-1]) << (Q_W - j);
         if (!sat_ff[j-1] && (rem_ff[j-1] >= trial[j])) begin
            rem_in[j] = rem_ff[j-1] - trial[j];
            q_in[j]   = q_ff[j-1] | (Q_W'(1) << (Q_W - j));
         end else begin
            rem_in[j] = rem_ff[j-1];
            q_in[j]   = q_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_ext;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= (num_ext >= den_top);
         for (int j = 1; j <= Q_W; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_ff[j-1];
            q_ff[j]   <= q_in[j];
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign quo = sat_ff[Q_W] ? '1 : q_ff[Q_W];

endmodule

>>> rtl/pgi_fifo.sv
// Short work queue between the front classifier and the back pipeline.
`include "pairwise_gravity_impulse_top_assert.svh"
module pgi_fifo
   import pgi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pgi_work_type      push_data,
   input  logic              pop,
   output pgi_work_type      head,
   output pgi_fifo_stat_type stat
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   pgi_work_type     mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);

   `PGI_ASSERT_NOW(a_fifo_no_overrun, push, cnt_ff != CNT_W'(FIFO_DEPTH), "push into full queue")
   `PGI_ASSERT_NOW(a_fifo_no_underrun, pop, cnt_ff != '0, "pop from empty queue")
   `PGI_ASSERT_NEXT(a_fifo_grows, push && !pop, !stat.empty, "queue empty after push")

endmodule

>>> rtl/pgi_front.sv
// Front stage: takes request beats, classifies the pair and queues the work.
module pgi_front
   import pgi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgi_req_type       req_data,
   input  logic              gravity_enable,
   input  pgi_fifo_stat_type fifo_stat,
   output logic              push,
   output pgi_work_type      push_data
);

   logic         hold_valid_ff, hold_valid_in;
   pgi_work_type hold_ff, hold_in;
   logic         accept;
   logic [32:0]  dx, dy;
   logic [32:0]  abs_x, abs_y;

   assign req_ready = !hold_valid_ff || !fifo_stat.full;
   assign accept    = req_valid && req_ready;
   assign push      = hold_valid_ff && !fifo_stat.full;
   assign push_data = hold_ff;

   always_comb begin
      dx    = {req_data.pos_b_x[31], req_data.pos_b_x} - {req_data.pos_a_x[31], req_data.pos_a_x};
      dy    = {req_data.pos_b_y[31], req_data.pos_b_y} - {req_data.pos_a_y[31], req_data.pos_a_y};
      abs_x = dx[32] ? (33'd0 - dx) : dx;
      abs_y = dy[32] ? (33'd0 - dy) : dy;

      hold_in.active   = gravity_enable && !req_data.removed_a && !req_data.removed_b
                         && !(req_data.fixed_a && req_data.fixed_b);
      hold_in.neg_x    = dx[32];
      hold_in.neg_y    = dy[32];
      hold_in.mag_x    = abs_x[31:0];
      hold_in.mag_y    = abs_y[31:0];
      hold_in.mass_a   = req_data.mass_a;
      hold_in.mass_b   = req_data.mass_b;
      hold_in.fixed_a  = req_data.fixed_a;
      hold_in.fixed_b  = req_data.fixed_b;
      hold_in.singular = hold_in.active
                         && ((abs_x == 33'd0 && abs_y == 33'd0)
                             || req_data.mass_a == 32'd0 || req_data.mass_b == 32'd0);

      hold_valid_in = accept || (hold_valid_ff && fifo_stat.full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

>>> rtl/pgi_back.sv
// Back pipeline: distance, force, nudges and the response register.
`include "pairwise_gravity_impulse_top_assert.svh"
module pgi_back
   import pgi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  pgi_cfg_type       cfg,
   input  pgi_fifo_stat_type fifo_stat,
   input  pgi_work_type      head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgi_rsp_type       rsp_data
);

   localparam int DIV_LAT = Q_W + 1;
   localparam int S_P2    = 2;
   localparam int S_P3    = S_P2 + DIV_LAT + 1;
   localparam int S_P6    = S_P3 + 3;
   localparam int LAT     = S_P6 + DIV_LAT + 1;
   localparam int S_W     = 65;
   localparam int GM_W    = 96;
   localparam int SQ_W    = 68;
   localparam int DEN0_W  = 65;
   localparam int DEN_W   = DEN0_W + FRAC_BITS;
   localparam int NUM_W   = 128;

   logic          adv;
   logic          vld_ff [0:LAT-1];
   pgi_work_type  sd_ff  [0:LAT-1];
   logic          rsp_valid_ff;
   pgi_rsp_type   rsp_data_ff, rsp_in;
   pgi_work_type  sd_out;

   logic [63:0]   sqx_ff, sqy_ff, gma_ff;
   logic [S_W-1:0] s_ff;
   logic [63:0]   gmlo_ff, gmhi_ff;
   logic [GM_W-1:0] gm_ff;

   logic [SQ_W-1:0]   sq_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [0:ROOT_W];
   logic [SQ_W-1:0]   sq_rem_in  [1:ROOT_W];
   logic [ROOT_W-1:0] sq_root_in [1:ROOT_W];
   logic [SQ_W-1:0]   sq_trial   [1:ROOT_W];

   logic [Q_W-1:0]    quo_force;
   logic [31:0]       force_ff;
   logic [ROOT_W-1:0] dist_ff;
   logic [63:0]       nmx_ff, nmy_ff;
   logic [DEN0_W-1:0] dena_ff, denb_ff, dena5_ff, denb5_ff;
   logic [63:0]       ppx_ff [4];
   logic [63:0]       ppy_ff [4];
   logic [NUM_W-1:0]  numx_ff, numy_ff;
   logic [DEN_W-1:0]  dena6_ff, denb6_ff;
   logic [Q_W-1:0]    q_ax, q_ay, q_bx, q_by;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop       = adv && !fifo_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign sd_out    = sd_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= !fifo_stat.empty;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   // integer square root, one root bit per stage
   always_comb begin
      for (int k = 1; k <= ROOT_W; k++) begin
         sq_trial[k] = (SQ_W'(sq_root_ff[k-1]) << (ROOT_W - k + 1))
                       | (SQ_W'(1) << (2 * (ROOT_W - k)));
         if (sq_rem_ff[k-1] >= sq_trial[k]) begin
            sq_rem_in[k]  = sq_rem_ff[k-1] - sq_trial[k];
            sq_root_in[k] = sq_root_ff[k-1] | (ROOT_W'(1) << (ROOT_W - k));
         end else begin
            sq_rem_in[k]  = sq_rem_ff[k-1];
            sq_root_in[k] = sq_root_ff[k-1];
         end
      end
   end

   pgi_div #(
      .NUM_W(GM_W),
      .DEN_W(S_W)
   ) u_div_force (
      .clock(clock),
      .en   (adv),
      .num  (gm_ff),
      .den  (sq_rem_ff[0][S_W-1:0]),
      .quo  (quo_force)
   );

   pgi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_ax (
      .clock(clock), .en(adv), .num(numx_ff), .den(dena6_ff), .quo(q_ax)
   );
   pgi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_ay (
      .clock(clock), .en(adv), .num(numy_ff), .den(dena6_ff), .quo(q_ay)
   );
   pgi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_bx (
      .clock(clock), .en(adv), .num(numx_ff), .den(denb6_ff), .quo(q_bx)
   );
   pgi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_by (
      .clock(clock), .en(adv), .num(numy_ff), .den(denb6_ff), .quo(q_by)
   );

   always_comb begin
      rsp_in = '0;
      if (sd_out.active) begin
         if (sd_out.singular) begin
            rsp_in.singular = 1'b1;
         end else begin
            if (!sd_out.fixed_a) begin
               rsp_in.nudge_a_x = sat_nudge(q_ax, sd_out.neg_x);
               rsp_in.nudge_a_y = sat_nudge(q_ay, sd_out.neg_y);
               rsp_in.apply_a   = 1'b1;
            end
            if (!sd_out.fixed_b) begin
               rsp_in.nudge_b_x = sat_nudge(q_bx, !sd_out.neg_x);
               rsp_in.nudge_b_y = sat_nudge(q_by, !sd_out.neg_y);
               rsp_in.apply_b   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff[0] <= head;
         for (int i = 1; i < LAT; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end

         sqx_ff <= 64'(head.mag_x) * 64'(head.mag_x);
         sqy_ff <= 64'(head.mag_y) * 64'(head.mag_y);
         gma_ff <= 64'(cfg.grav_constant) * 64'(head.mass_a);

         s_ff    <= S_W'(sqx_ff) + S_W'(sqy_ff);
         gmlo_ff <= 64'(gma_ff[31:0]) * 64'(sd_ff[0].mass_b);
         gmhi_ff <= 64'(gma_ff[63:32]) * 64'(sd_ff[0].mass_b);

         gm_ff         <= {gmhi_ff, 32'd0} + GM_W'(gmlo_ff);
         sq_rem_ff[0]  <= SQ_W'(s_ff);
         sq_root_ff[0] <= '0;
         for (int k = 1; k <= ROOT_W; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
         end

         force_ff <= (quo_force > cfg.force_limit) ? cfg.force_limit : quo_force;
         dist_ff  <= sq_root_ff[ROOT_W];

         nmx_ff  <= 64'(sd_ff[S_P3].mag_x) * 64'(force_ff);
         nmy_ff  <= 64'(sd_ff[S_P3].mag_y) * 64'(force_ff);
         dena_ff <= DEN0_W'(dist_ff) * DEN0_W'(sd_ff[S_P3].mass_a);
         denb_ff <= DEN0_W'(dist_ff) * DEN0_W'(sd_ff[S_P3].mass_b);

         ppx_ff[0] <= 64'(nmx_ff[31:0])  * 64'(cfg.dt_sq[31:0]);
         ppx_ff[1] <= 64'(nmx_ff[31:0])  * 64'(cfg.dt_sq[63:32]);
         ppx_ff[2] <= 64'(nmx_ff[63:32]) * 64'(cfg.dt_sq[31:0]);
         ppx_ff[3] <= 64'(nmx_ff[63:32]) * 64'(cfg.dt_sq[63:32]);
         ppy_ff[0] <= 64'(nmy_ff[31:0])  * 64'(cfg.dt_sq[31:0]);
         ppy_ff[1] <= 64'(nmy_ff[31:0])  * 64'(cfg.dt_sq[63:32]);
         ppy_ff[2] <= 64'(nmy_ff[63:32]) * 64'(cfg.dt_sq[31:0]);
         ppy_ff[3] <= 64'(nmy_ff[63:32]) * 64'(cfg.dt_sq[63:32]);
         dena5_ff  <= dena_ff;
         denb5_ff  <= denb_ff;

         numx_ff  <= NUM_W'(ppx_ff[0]) + (NUM_W'(ppx_ff[1]) << 32)
                     + (NUM_W'(ppx_ff[2]) << 32) + (NUM_W'(ppx_ff[3]) << 64);
         numy_ff  <= NUM_W'(ppy_ff[0]) + (NUM_W'(ppy_ff[1]) << 32)
                     + (NUM_W'(ppy_ff[2]) << 32) + (NUM_W'(ppy_ff[3]) << 64);
         dena6_ff <= {dena5_ff, {FRAC_BITS{1'b0}}};
         denb6_ff <= {denb5_ff, {FRAC_BITS{1'b0}}};

         rsp_data_ff <= rsp_in;
      end
   end

   `PGI_ASSERT_NOW(a_singular_blocks, rsp_valid_ff && rsp_data_ff.singular, !rsp_data_ff.apply_a && !rsp_data_ff.apply_b, "singular beat applies a nudge")
   `PGI_ASSERT_NOW(a_idle_a_zero, rsp_valid_ff && !rsp_data_ff.apply_a, rsp_data_ff.nudge_a_x == '0 && rsp_data_ff.nudge_a_y == '0, "unapplied nudge a not zero")
   `PGI_ASSERT_NOW(a_idle_b_zero, rsp_valid_ff && !rsp_data_ff.apply_b, rsp_data_ff.nudge_b_x == '0 && rsp_data_ff.nudge_b_y == '0, "unapplied nudge b not zero")

endmodule
